// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated off while rst is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, gated off while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/lehm_pkg.sv
// shared types and constant tables for the lehmer unrank pipeline
`timescale 1ns / 1ps
`default_nettype none

package lehm_pkg;

   localparam int unsigned ElemCount = 8;
   localparam int unsigned StepCount = 7;

   localparam logic [15:0] RANK_LIMIT = 16'd40320;

   localparam logic STATUS_OK           = 1'b0;
   localparam logic STATUS_OUT_OF_RANGE = 1'b1;

   // multiples 1..7 of the factorial weight of each digit, 7! down to 0!
   localparam logic [15:0] DIGIT_STEP [ElemCount][StepCount] = '{
      '{16'd5040, 16'd10080, 16'd15120, 16'd20160, 16'd25200, 16'd30240, 16'd35280},
      '{16'd720,  16'd1440,  16'd2160,  16'd2880,  16'd3600,  16'd4320,  16'd5040},
      '{16'd120,  16'd240,   16'd360,   16'd480,   16'd600,   16'd720,   16'd840},
      '{16'd24,   16'd48,    16'd72,    16'd96,    16'd120,   16'd144,   16'd168},
      '{16'd6,    16'd12,    16'd18,    16'd24,    16'd30,    16'd36,    16'd42},
      '{16'd2,    16'd4,     16'd6,     16'd8,     16'd10,    16'd12,    16'd14},
      '{16'd1,    16'd2,     16'd3,     16'd4,     16'd5,     16'd6,     16'd7},
      '{16'd1,    16'd2,     16'd3,     16'd4,     16'd5,     16'd6,     16'd7}
   };

   // word carried from cell to cell
   typedef struct packed {
      logic             err;
      logic [15:0]      rest;
      logic [7:0][2:0]  pool;
      logic [7:0][2:0]  perm;
   } cell_data_type;

   // ordered list of unused elements at the head of the chain
   localparam logic [7:0][2:0] POOL_INIT = {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

endpackage

`default_nettype wire

// File: hdl/permutation_lehmer_unrank_top.sv
// top level: eight-cell pipeline unranking a permutation of eight elements
//
//   channel | direction | words
//   req     | in        | rank_value (16 bits)
//   rsp     | out       | perm_0..perm_7 (3 bits each), status_code (1 bit)
//
// one word enters per cycle while the chain is not stalled; each result passes
// through the register of every digit cell in the chain.
// each cell holds its word until the next cell takes it, so a stall on rsp
// fills bubbles first and only then drops req_ready.
// reset empties the chain; no result is pending after it.
`timescale 1ns / 1ps
`default_nettype none

module permutation_lehmer_unrank_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_rank_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_perm_0,
   output logic [2:0]       rsp_perm_1,
   output logic [2:0]       rsp_perm_2,
   output logic [2:0]       rsp_perm_3,
   output logic [2:0]       rsp_perm_4,
   output logic [2:0]       rsp_perm_5,
   output logic [2:0]       rsp_perm_6,
   output logic [2:0]       rsp_perm_7,
   output logic             rsp_status_code
);

   lehm_pkg::cell_data_type chain_data  [lehm_pkg::ElemCount + 1];
   logic                    chain_valid [lehm_pkg::ElemCount + 1];
   logic                    chain_ready [lehm_pkg::ElemCount + 1];
   logic [7:0][2:0]         perm_out;

   // head of the chain: range check and fresh element list
   always_comb begin
      chain_data[0].err  = (req_rank_value >= lehm_pkg::RANK_LIMIT);
      chain_data[0].rest = req_rank_value;
      chain_data[0].pool = lehm_pkg::POOL_INIT;
      chain_data[0].perm = '0;
   end
   assign chain_valid[0] = req_valid;
   assign req_ready      = chain_ready[0];

   // row of digit cells, 7! weight first
   for (genvar i = 0; i < lehm_pkg::ElemCount; i++) begin : g_cell
      lehm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage     (3'(i)),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i + 1]),
         .out_ready (chain_ready[i + 1]),
         .out_data  (chain_data[i + 1])
      );
   end

   // tail of the chain: out-of-range words give all zeros
   assign rsp_valid                   = chain_valid[lehm_pkg::ElemCount];
   assign chain_ready[lehm_pkg::ElemCount] = rsp_ready;
   assign perm_out = chain_data[lehm_pkg::ElemCount].err ? '0
                                                          : chain_data[lehm_pkg::ElemCount].perm;
   assign rsp_status_code = chain_data[lehm_pkg::ElemCount].err ? lehm_pkg::STATUS_OUT_OF_RANGE
                                                                 : lehm_pkg::STATUS_OK;
   assign rsp_perm_0 = perm_out[0];
   assign rsp_perm_1 = perm_out[1];
   assign rsp_perm_2 = perm_out[2];
   assign rsp_perm_3 = perm_out[3];
   assign rsp_perm_4 = perm_out[4];
   assign rsp_perm_5 = perm_out[5];
   assign rsp_perm_6 = perm_out[6];
   assign rsp_perm_7 = perm_out[7];

endmodule

`default_nettype wire

// File: hdl/lehm_cell.sv
// one digit cell: extracts a factorial digit, picks and removes one element
`timescale 1ns / 1ps
`default_nettype none

module lehm_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [2:0]              stage,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire lehm_pkg::cell_data_type in_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output lehm_pkg::cell_data_type      out_data
);

   logic                    valid_ff;
   logic                    valid_in;
   lehm_pkg::cell_data_type data_ff;
   lehm_pkg::cell_data_type data_in;

   logic [2:0]  digit;
   logic [2:0]  digit_c;
   logic [3:0]  left;
   logic [15:0] sub;

   // digit by parallel compares against the weight multiples
   always_comb begin
      digit = 3'd0;
      for (int k = 0; k < lehm_pkg::StepCount; k++) begin
         if (in_data.rest >= lehm_pkg::DIGIT_STEP[stage][k]) begin
            digit = 3'(k + 1);
         end
      end
   end

   // remainder and clamp to the remaining list length
   always_comb begin
      sub     = (digit == 3'd0) ? 16'd0 : lehm_pkg::DIGIT_STEP[stage][digit - 3'd1];
      left    = 4'd8 - {1'b0, stage};
      digit_c = ({1'b0, digit} >= left) ? 3'(left - 4'd1) : digit;
   end

   // pick the element, close the gap in the list
   always_comb begin
      data_in      = in_data;
      data_in.rest = in_data.rest - sub;
      data_in.perm[stage] = in_data.pool[digit_c];
      for (int k = 0; k < lehm_pkg::ElemCount - 1; k++) begin
         data_in.pool[k] = (3'(k) < digit_c) ? in_data.pool[k] : in_data.pool[k + 1];
      end
   end

   // stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: hdl/lehm_checker.sv
// port-level checks on the unrank pipeline, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lehm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [15:0] req_rank_value,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_perm_0,
   input wire logic [2:0]  rsp_perm_1,
   input wire logic [2:0]  rsp_perm_2,
   input wire logic [2:0]  rsp_perm_3,
   input wire logic [2:0]  rsp_perm_4,
   input wire logic [2:0]  rsp_perm_5,
   input wire logic [2:0]  rsp_perm_6,
   input wire logic [2:0]  rsp_perm_7,
   input wire logic        rsp_status_code
);

   logic [7:0] seen;
   logic       perm_zero;

   // which elements appear in the result word
   always_comb begin
      seen = (8'd1 << rsp_perm_0) | (8'd1 << rsp_perm_1) | (8'd1 << rsp_perm_2)
           | (8'd1 << rsp_perm_3) | (8'd1 << rsp_perm_4) | (8'd1 << rsp_perm_5)
           | (8'd1 << rsp_perm_6) | (8'd1 << rsp_perm_7);
      perm_zero = (rsp_perm_0 == 3'd0) && (rsp_perm_1 == 3'd0) && (rsp_perm_2 == 3'd0)
               && (rsp_perm_3 == 3'd0) && (rsp_perm_4 == 3'd0) && (rsp_perm_5 == 3'd0)
               && (rsp_perm_6 == 3'd0) && (rsp_perm_7 == 3'd0);
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid && rsp_status_code, perm_zero)
   `ASSERT_IMPLIES(a_perm_full, clock, reset, rsp_valid && !rsp_status_code, seen == 8'hFF)
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_rank_value))

endmodule

bind permutation_lehmer_unrank_top lehm_checker u_lehm_checker (.*);

`default_nettype wire

// File: verif/tb_top.sv
// testbench for the lehmer code permutation unrank pipeline
`timescale 1ns / 1ps

module tb_top;

   // expected result of one rank: element per position plus status
   typedef struct packed {
      logic [7:0][2:0] perm;
      logic            status;
   } perm_word_type;

   typedef struct {
      logic [15:0]   rank;
      perm_word_type word;
   } pending_perm_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_rank_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_perm_0;
   logic [2:0]  rsp_perm_1;
   logic [2:0]  rsp_perm_2;
   logic [2:0]  rsp_perm_3;
   logic [2:0]  rsp_perm_4;
   logic [2:0]  rsp_perm_5;
   logic [2:0]  rsp_perm_6;
   logic [2:0]  rsp_perm_7;
   logic        rsp_status_code;

   pending_perm_type expected_perms[$];
   int               mismatch_count = 0;
   int               req_idle_pct = 0;
   int               rsp_idle_pct = 0;
   int               rsp_hold_cycles = 0;
   bit               rsp_hold_request = 0;

   permutation_lehmer_unrank_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rank_value  (req_rank_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_perm_0      (rsp_perm_0),
      .rsp_perm_1      (rsp_perm_1),
      .rsp_perm_2      (rsp_perm_2),
      .rsp_perm_3      (rsp_perm_3),
      .rsp_perm_4      (rsp_perm_4),
      .rsp_perm_5      (rsp_perm_5),
      .rsp_perm_6      (rsp_perm_6),
      .rsp_perm_7      (rsp_perm_7),
      .rsp_status_code (rsp_status_code)
   );

   // clock generation
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // unrank: factorial-base digits pick from the list of unused elements
   function automatic perm_word_type unrank_permutation(input logic [15:0] rank);
      int unsigned   weights[8] = '{5040, 720, 120, 24, 6, 2, 1, 1};
      logic [2:0]    unused[8];
      int unsigned   remaining;
      int unsigned   digit;
      int unsigned   avail;
      perm_word_type word;
      word = '0;
      if (rank >= lehm_pkg::RANK_LIMIT) begin
         word.status = lehm_pkg::STATUS_OUT_OF_RANGE;
         return word;
      end
      for (int i = 0; i < 8; i++) unused[i] = 3'(i);
      remaining = rank;
      avail = 8;
      for (int pos = 0; pos < 8; pos++) begin
         digit = remaining / weights[pos];
         remaining = remaining % weights[pos];
         // cannot trigger for a legal rank, kept for safety
         if (digit >= avail) digit = avail - 1;
         word.perm[pos] = unused[digit];
         for (int k = digit; k + 1 < avail; k++) unused[k] = unused[k + 1];
         avail--;
      end
      word.status = lehm_pkg::STATUS_OK;
      return word;
   endfunction

   // idle length: mostly short, now and then long
   function automatic int pick_gap(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   // random rank: mostly legal, some above the limit, some raw 16-bit
   function automatic logic [15:0] pick_rank();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 8) return 16'($urandom_range(0, 40319));
      if (sel == 8) return 16'($urandom_range(40320, 65535));
      return 16'($urandom);
   endfunction

   // offer one word and wait until it is taken
   task automatic send_rank(input logic [15:0] rank);
      int gap;
      gap = pick_gap(req_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_rank_value <= rank;
      do @(posedge clock); while (!req_ready);
   endtask

   // response-side ready with random stalls and the occasional long hold
   initial begin : drive_rsp_ready
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            stall_left = rsp_hold_cycles;
            rsp_hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left = pick_gap(rsp_idle_pct);
         end
      end
   end

   // record accepted ranks and check each returned permutation
   always @(posedge clock) begin : check_results
      pending_perm_type want;
      perm_word_type    seen;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want.rank = req_rank_value;
            want.word = unrank_permutation(req_rank_value);
            expected_perms.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            seen.perm   = {rsp_perm_7, rsp_perm_6, rsp_perm_5, rsp_perm_4,
                           rsp_perm_3, rsp_perm_2, rsp_perm_1, rsp_perm_0};
            seen.status = rsp_status_code;
            if (expected_perms.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: perm %h status %0d", seen.perm, seen.status);
            end else begin
               want = expected_perms.pop_front();
               for (int pos = 0; pos < 8; pos++) begin
                  if (seen.perm[pos] !== want.word.perm[pos]) begin
                     mismatch_count++;
                     if (mismatch_count <= 10)
                        $display("rank %0d perm_%0d: expected %0d, got %0d",
                                 want.rank, pos, want.word.perm[pos], seen.perm[pos]);
                  end
               end
               if (seen.status !== want.word.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("rank %0d status_code: expected %0d, got %0d",
                              want.rank, want.word.status, seen.status);
               end
            end
         end
      end
   end

   // boundaries, digit carries and alternating bit patterns
   task automatic test_extreme_ranks();
      logic [15:0] ranks[19] = '{16'd0, 16'd1, 16'd2, 16'd6, 16'd23, 16'd24,
                                 16'd119, 16'd120, 16'd719, 16'd720, 16'd5039,
                                 16'd5040, 16'd35280, 16'd40319, 16'd40320,
                                 16'd40321, 16'h5555, 16'hAAAA, 16'hFFFF};
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      foreach (ranks[i]) send_rank(ranks[i]);
   endtask

   // back-to-back words with no idling on either side
   task automatic test_streaming(input int count);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (count) send_rank(pick_rank());
   endtask

   // long response hold while words keep coming, so the chain fills
   task automatic test_output_backpressure(input int count);
      req_idle_pct     = 0;
      rsp_idle_pct     = 0;
      rsp_hold_cycles  = 80;
      rsp_hold_request = 1;
      repeat (count) send_rank(pick_rank());
   endtask

   // random ranks under a given idling mix
   task automatic test_random_ranks(input int count, input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (count) send_rank(pick_rank());
   endtask

   // main sequence
   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_rank_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_ranks();
      test_streaming(100);
      test_output_backpressure(40);
      test_random_ranks(300, 30, 30);
      test_random_ranks(300, 10, 50);
      test_random_ranks(300, 50, 10);

      req_valid <= 1'b0;
      while (expected_perms.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_perms.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: permutation_lehmer_unrank_top.f
+incdir+hdl
hdl/lehm_pkg.sv
hdl/lehm_cell.sv
hdl/permutation_lehmer_unrank_top.sv
hdl/lehm_checker.sv
verif/tb_top.sv
